FILE: rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] HDR_EXT16_BYTES = 4'd2;
    localparam logic [3:0] HDR_EXT64_BYTES = 4'd8;
    localparam logic [3:0] HDR_MASK_BYTES  = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_MASK   = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNMASKED     = 3'd1,
        ERR_TOO_LONG     = 3'd2,
        ERR_BAD_OPCODE   = 3'd3,
        ERR_TEXT_IN_CONT = 3'd4,
        ERR_ORPHAN_CONT  = 3'd5
    } t_err;

    typedef struct packed {
        logic       is_data;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       fin;
        logic       frame_end;
        logic       message_end;
        t_err       err;
    } t_cmd;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        logic       frame_end;
        logic       message_end;
        t_err       error_code;
    } t_result;

endpackage

FILE: rtl/wsd_ifs.sv
// Stream channel interfaces: raw client bytes in, deframed results out.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       frame_end;
    logic       message_end;
    logic [2:0] error_code;

    modport source (
        output valid, output payload_valid, output payload_byte, output frame_opcode,
        output frame_fin, output frame_end, output message_end, output error_code,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input frame_opcode,
        input frame_fin, input frame_end, input message_end, input error_code,
        output ready
    );
endinterface

FILE: rtl/wsd_front.sv
// Header parser: accepts stream bytes, tracks frame state, queues one command per byte.
module wsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    wsd_in_if.sink               i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output wsd_pkg::t_cmd        o_cmd
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    t_err        r_err, n_err;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_op, n_op;
    logic        r_fin, n_fin;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_midx, n_midx;
    logic        r_cont, n_cont;
    logic [31:0] r_max_payload;

    logic        accept;
    logic        do_len;
    logic        fend;
    logic [63:0] len_new;
    logic [31:0] key_sh;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign key_sh     = r_key >> {~r_midx, 3'b000};

    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_fin   = r_fin;
        n_rem   = r_rem;
        n_key   = r_key;
        n_midx  = r_midx;
        n_cont  = r_cont;
        do_len  = 1'b0;
        fend    = 1'b0;
        len_new = r_rem;
        o_cmd.is_data = 1'b0;
        if (accept && r_err == ERR_NONE) begin
            case (r_phase)
                PH_HDR0: begin
                    n_fin   = i_in.stream_byte[7];
                    n_op    = i_in.stream_byte[3:0];
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    if (!i_in.stream_byte[7]) begin
                        n_err = ERR_UNMASKED;
                    end else if (i_in.stream_byte[6:0] == LEN_EXT16) begin
                        n_rem   = '0;
                        n_cnt   = HDR_EXT16_BYTES;
                        n_phase = PH_EXTLEN;
                    end else if (i_in.stream_byte[6:0] == LEN_EXT64) begin
                        n_rem   = '0;
                        n_cnt   = HDR_EXT64_BYTES;
                        n_phase = PH_EXTLEN;
                    end else begin
                        len_new = {57'd0, i_in.stream_byte[6:0]};
                        n_rem   = len_new;
                        do_len  = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    len_new = {r_rem[55:0], i_in.stream_byte};
                    n_rem   = len_new;
                    n_cnt   = r_cnt - 4'd1;
                    do_len  = (r_cnt == 4'd1);
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_in.stream_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        n_midx = '0;
                        if (r_rem == 64'd0) begin
                            fend    = 1'b1;
                            n_phase = PH_HDR0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    o_cmd.is_data = 1'b1;
                    n_midx = r_midx + 2'd1;
                    n_rem  = r_rem - 64'd1;
                    if (r_rem == 64'd1) begin
                        fend    = 1'b1;
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
            if (do_len) begin
                if (len_new[63:32] != 32'd0 || len_new[31:0] > r_max_payload) begin
                    n_err = ERR_TOO_LONG;
                end else if (r_op == OP_TEXT && r_cont) begin
                    n_err = ERR_TEXT_IN_CONT;
                end else if (r_op == OP_CONT && !r_cont) begin
                    n_err = ERR_ORPHAN_CONT;
                end else if (r_op != OP_TEXT && r_op != OP_CONT && r_op != OP_CLOSE
                             && r_op != OP_PING && r_op != OP_PONG) begin
                    n_err = ERR_BAD_OPCODE;
                end else begin
                    if (r_op == OP_TEXT && !r_fin) begin
                        n_cont = 1'b1;
                    end
                    if (r_op == OP_CONT && r_fin) begin
                        n_cont = 1'b0;
                    end
                    n_phase = PH_MASK;
                    n_cnt   = HDR_MASK_BYTES;
                end
            end
        end
        o_push            = accept;
        o_cmd.raw_byte    = i_in.stream_byte;
        o_cmd.key_byte    = key_sh[7:0];
        o_cmd.opcode      = n_op;
        o_cmd.fin         = n_fin;
        o_cmd.frame_end   = fend;
        o_cmd.message_end = fend && n_fin && (n_op == OP_CONT || n_op == OP_TEXT);
        o_cmd.err         = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_err         <= ERR_NONE;
            r_cnt         <= '0;
            r_op          <= '0;
            r_fin         <= 1'b0;
            r_rem         <= '0;
            r_key         <= '0;
            r_midx        <= '0;
            r_cont        <= 1'b0;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
            r_fin   <= n_fin;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_midx  <= n_midx;
            r_cont  <= n_cont;
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_wdata;
            end
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("sticky error changed");

    a_data_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != 64'd0))
        else $error("payload phase with zero remaining length");

endmodule

FILE: rtl/wsd_fifo.sv
// Short command queue between the header parser and the output stage.
module wsd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output wsd_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import wsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

FILE: rtl/wsd_back.sv
// Output stage: unmask payload bytes and hold the result until transferred.
module wsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wsd_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    wsd_out_if.source     o_out
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res, n_res;

    assign o_pop = (!r_valid || o_out.ready) && !i_empty;

    always_comb begin
        n_res.payload_valid = i_cmd.is_data;
        n_res.payload_byte  = i_cmd.is_data ? (i_cmd.raw_byte ^ i_cmd.key_byte) : 8'd0;
        n_res.frame_opcode  = i_cmd.opcode;
        n_res.frame_fin     = i_cmd.fin;
        n_res.frame_end     = i_cmd.frame_end;
        n_res.message_end   = i_cmd.message_end;
        n_res.error_code    = i_cmd.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_valid = r_res.payload_valid;
    assign o_out.payload_byte  = r_res.payload_byte;
    assign o_out.frame_opcode  = r_res.frame_opcode;
    assign o_out.frame_fin     = r_res.frame_fin;
    assign o_out.frame_end     = r_res.frame_end;
    assign o_out.message_end   = r_res.message_end;
    assign o_out.error_code    = r_res.error_code;

    a_data_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.payload_valid) |-> (r_res.error_code == ERR_NONE))
        else $error("payload byte reported with an error");

endmodule

FILE: rtl/websocket_client_frame_deframer.sv
// WebSocket client frame deframer top level. Takes one client byte per cycle and
// returns exactly one result per byte: header bytes give a result with payload_valid
// low, payload bytes come out unmasked, and the frame's last byte (or the last mask
// key byte of an empty frame) carries frame_end and, for a finished text message,
// message_end. A byte is taken each cycle while the command queue has room, so the
// sustained rate is one byte per cycle while the output is ready; each result passes
// through the command queue and then the output register. Errors stick until reset.
// The user must write max_payload via i_cfg_we/i_cfg_wdata while idle (unchecked).
module websocket_client_frame_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    wsd_in_if.sink      i_in,
    wsd_out_if.source   o_out
);
    import wsd_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, empty, full;

    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    wsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: tb/wsd_checker.sv
// Deframer scoreboard: predicts each result from the accepted client bytes and compares.
module wsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    wsd_in_if           i_in,
    wsd_out_if          i_out,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int PEND_DEPTH = 16;

    logic [31:0] max_len;
    t_phase      phase;
    logic [3:0]  hdr_left;
    logic [3:0]  op;
    logic        fin;
    logic [63:0] left;
    logic [31:0] key;
    logic [1:0]  key_idx;
    logic        in_frag;
    t_err        err;
    t_result     pending [PEND_DEPTH];
    int          pend_head;
    int          pend_tail;
    int          pend_count;
    int          fails = 0;

    function automatic void finish_length();
        if (left > {32'd0, max_len}) begin
            err = ERR_TOO_LONG;
        end else if (op == OP_TEXT && in_frag) begin
            err = ERR_TEXT_IN_CONT;
        end else if (op == OP_CONT && !in_frag) begin
            err = ERR_ORPHAN_CONT;
        end else if (!(op inside {OP_CONT, OP_TEXT, OP_CLOSE, OP_PING, OP_PONG})) begin
            err = ERR_BAD_OPCODE;
        end else begin
            if (op == OP_TEXT && !fin) in_frag = 1'b1;
            if (op == OP_CONT && fin) in_frag = 1'b0;
            phase    = PH_MASK;
            hdr_left = HDR_MASK_BYTES;
            key      = '0;
        end
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result    r;
        logic [7:0] key_byte;
        r = '0;
        if (err == ERR_NONE) begin
            case (phase)
                PH_HDR0: begin
                    fin   = b[7];
                    op    = b[3:0];
                    phase = PH_HDR1;
                end
                PH_HDR1: begin
                    if (!b[7]) begin
                        err = ERR_UNMASKED;
                    end else begin
                        left = '0;
                        if (b[6:0] == LEN_EXT16) begin
                            hdr_left = HDR_EXT16_BYTES;
                            phase    = PH_EXTLEN;
                        end else if (b[6:0] == LEN_EXT64) begin
                            hdr_left = HDR_EXT64_BYTES;
                            phase    = PH_EXTLEN;
                        end else begin
                            left = {57'd0, b[6:0]};
                            finish_length();
                        end
                    end
                end
                PH_EXTLEN: begin
                    left     = {left[55:0], b};
                    hdr_left = hdr_left - 4'd1;
                    if (hdr_left == 4'd0) finish_length();
                end
                PH_MASK: begin
                    key      = {key[23:0], b};
                    hdr_left = hdr_left - 4'd1;
                    if (hdr_left == 4'd0) begin
                        key_idx = '0;
                        if (left == 64'd0) begin
                            r.frame_end = 1'b1;
                            phase       = PH_HDR0;
                        end else begin
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    key_byte        = 8'(key >> (24 - 8 * int'(key_idx)));
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b ^ key_byte;
                    key_idx         = key_idx + 2'd1;
                    left            = left - 64'd1;
                    if (left == 64'd0) begin
                        r.frame_end = 1'b1;
                        phase       = PH_HDR0;
                    end
                end
                default: begin
                    phase = PH_HDR0;
                end
            endcase
        end
        r.frame_opcode = op;
        r.frame_fin    = fin;
        r.message_end  = r.frame_end && fin && (op == OP_CONT || op == OP_TEXT);
        r.error_code   = err;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            max_len    = MAX_PAYLOAD_RST;
            phase      = PH_HDR0;
            hdr_left   = '0;
            op         = '0;
            fin        = 1'b0;
            left       = '0;
            key        = '0;
            key_idx    = '0;
            in_frag    = 1'b0;
            err        = ERR_NONE;
            pend_head  = 0;
            pend_tail  = 0;
            pend_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pend_count == 0) begin
                    $error("result transfer with no result pending");
                    fails++;
                end else begin
                    want       = pending[pend_head];
                    pend_head  = (pend_head + 1) % PEND_DEPTH;
                    pend_count = pend_count - 1;
                    compare_field("payload_valid", want.payload_valid, i_out.payload_valid);
                    compare_field("payload_byte", want.payload_byte, i_out.payload_byte);
                    compare_field("frame_opcode", want.frame_opcode, i_out.frame_opcode);
                    compare_field("frame_fin", want.frame_fin, i_out.frame_fin);
                    compare_field("frame_end", want.frame_end, i_out.frame_end);
                    compare_field("message_end", want.message_end, i_out.message_end);
                    compare_field("error_code", want.error_code, i_out.error_code);
                end
            end
            if (i_cfg_we) max_len = i_cfg_wdata;
            if (i_in.valid && i_in.ready) begin
                if (pend_count == PEND_DEPTH) begin
                    $error("more results pending than the block can hold");
                    fails++;
                end else begin
                    pending[pend_tail] = deframe_byte(i_in.stream_byte);
                    pend_tail          = (pend_tail + 1) % PEND_DEPTH;
                    pend_count         = pend_count + 1;
                end
            end
        end
        o_outstanding <= pend_count;
        o_fail_count  <= fails;
    end

endmodule

FILE: tb/tb_websocket_client_frame_deframer.sv
// Testbench top for the WebSocket frame deframer: clock, reset, frame stimulus and verdict.
module tb_websocket_client_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    typedef enum logic [1:0] {
        LEN_IN_HEADER,
        LEN_16,
        LEN_64
    } t_len_form;

    localparam int PHASE_BYTES    = 150;
    localparam int STALL_PCT      = 31;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NOISE_BYTES    = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          outstanding;
    bit          steady;
    bit          in_msg;
    logic [31:0] cur_max;
    int          sent_bytes;
    int          idle_cycles;

    wsd_in_if  in_ch ();
    wsd_out_if out_ch ();

    websocket_client_frame_deframer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    wsd_checker u_scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("websocket_client_frame_deframer test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sent_bytes++;
    endtask

    // Drop valid and hold until every result has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_max_payload(input logic [31:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_max = value;
    endtask

    task automatic send_header(input logic [3:0] op, input logic fin, input logic masked,
                               input logic [63:0] len, input t_len_form form);
        logic [6:0] len_field;
        send_byte({fin, 3'($urandom), op});
        case (form)
            LEN_16:  len_field = LEN_EXT16;
            LEN_64:  len_field = LEN_EXT64;
            default: len_field = len[6:0];
        endcase
        send_byte({masked, len_field});
        if (form == LEN_16) begin
            for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
        end else if (form == LEN_64) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
        end
    endtask

    task automatic send_frame(input logic [3:0] op, input logic fin, input logic [63:0] len,
                              input t_len_form form, input logic [31:0] key);
        send_header(op, fin, 1'b1, len, form);
        if (op == OP_TEXT && !fin) in_msg = 1'b1;
        if (op == OP_CONT && fin) in_msg = 1'b0;
        for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        for (longint unsigned n = 0; n < len; n++) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic [63:0] len;
        t_len_form   form;
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(2))
                0:       op = OP_CLOSE;
                1:       op = OP_PING;
                default: op = OP_PONG;
            endcase
            fin = 1'($urandom_range(1));
        end else if (in_msg) begin
            op  = OP_CONT;
            fin = ($urandom_range(2) == 0);
        end else begin
            op  = OP_TEXT;
            fin = 1'($urandom_range(1));
        end
        if ($urandom_range(99) < 6) len = 64'($urandom_range(300, 120));
        else len = 64'($urandom_range(12));
        if (len > {32'd0, cur_max}) len = {32'd0, cur_max};
        if (len > 64'd125) begin
            form = ($urandom_range(1) == 0) ? LEN_16 : LEN_64;
        end else begin
            case ($urandom_range(3))
                0:       form = LEN_16;
                1:       form = LEN_64;
                default: form = LEN_IN_HEADER;
            endcase
        end
        send_frame(op, fin, len, form, $urandom);
    endtask

    initial begin
        logic [31:0] limits [7];
        logic [3:0]  op;
        int          phase_end;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.stream_byte <= '0;
        steady     = 1'b0;
        in_msg     = 1'b0;
        cur_max    = MAX_PAYLOAD_RST;
        sent_bytes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(OP_TEXT, 1'b1, 64'd0, LEN_IN_HEADER, 32'h0000_0000);
        send_frame(OP_TEXT, 1'b0, 64'd1, LEN_16, 32'hFFFF_FFFF);
        send_frame(OP_PING, 1'b1, 64'd1, LEN_64, $urandom);
        send_frame(OP_CONT, 1'b1, 64'd2, LEN_IN_HEADER, $urandom);
        while (sent_bytes < PHASE_BYTES) send_random_frame();

        limits[0] = 32'd0;
        limits[1] = 32'd1;
        limits[2] = 32'hFFFF_FFFF;
        limits[3] = 32'd125;
        limits[4] = 32'd126;
        limits[5] = $urandom;
        limits[6] = 32'($urandom_range(300));
        foreach (limits[p]) begin
            write_max_payload(limits[p]);
            steady    = (p == 3);
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end) send_random_frame();
        end
        steady = 1'b0;

        // One protocol error per run; the block then stops parsing, flagging every later result.
        case ($urandom_range(4))
            0: begin
                send_header(in_msg ? OP_CONT : OP_TEXT, 1'($urandom_range(1)), 1'b0,
                            64'($urandom_range(125)), LEN_IN_HEADER);
            end
            1: begin
                op = 4'($urandom);
                if ($urandom_range(1) == 0) begin
                    write_max_payload(32'hFFFF_FFFF);
                    send_header(op, 1'b1, 1'b1,
                                {32'($urandom_range(1000, 1)), 32'($urandom)}, LEN_64);
                end else begin
                    write_max_payload(32'($urandom_range(124)));
                    send_header(op, 1'b1, 1'b1, 64'(cur_max) + 64'd1, LEN_IN_HEADER);
                end
            end
            2: begin
                do op = 4'($urandom);
                while (op inside {OP_CONT, OP_TEXT, OP_CLOSE, OP_PING, OP_PONG});
                send_header(op, 1'($urandom_range(1)), 1'b1, 64'd0, LEN_16);
            end
            3: begin
                if (!in_msg) send_frame(OP_TEXT, 1'b0, 64'd0, LEN_IN_HEADER, $urandom);
                send_header(OP_TEXT, 1'($urandom_range(1)), 1'b1, 64'd0, LEN_IN_HEADER);
            end
            default: begin
                if (in_msg) send_frame(OP_CONT, 1'b1, 64'd0, LEN_IN_HEADER, $urandom);
                send_header(OP_CONT, 1'($urandom_range(1)), 1'b1, 64'd0, LEN_IN_HEADER);
            end
        endcase
        repeat (NOISE_BYTES) send_byte(8'($urandom));

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("websocket_client_frame_deframer test passed");
        end else begin
            $display("websocket_client_frame_deframer test failed");
        end
        $finish;
    end

endmodule
